@@ sv/wmf_pkg.sv @@
// ============================================================================
// Window majority input filter package
// Shared widths, configuration register indexes, reset values and types.
// ============================================================================
package wmf_pkg;

    localparam int WORD_W    = 16;
    localparam int CL_W      = 4;
    localparam int MA_W      = 5;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_AGREE    = 1'b1;

    localparam logic [CL_W-1:0] CHANGE_LIMIT_RST = 4'd2;
    localparam logic [MA_W-1:0] MIN_AGREE_RST    = 5'd3;

    typedef struct packed {
        logic [CL_W-1:0] change_limit;
        logic [MA_W-1:0] min_agree;
    } cfg_t;

endpackage

@@ sv/wmf_lane.sv @@
// ============================================================================
// Window majority filter lane
// Counts ones, zeros and level changes of one channel over the sample window
// and registers the counts when the pipeline advances.
// ============================================================================
module wmf_lane #(
    parameter int WINDOW = 5,
    parameter int CNT_W  = 3
) (
    input  logic              clk,
    input  logic              load,
    input  logic [WINDOW-1:0] window_bits,
    output logic [CNT_W-1:0]  ones,
    output logic [CNT_W-1:0]  zeros,
    output logic [CNT_W-1:0]  changes
);

    logic [CNT_W-1:0] ones_reg;
    logic [CNT_W-1:0] zeros_reg;
    logic [CNT_W-1:0] changes_reg;
    logic [CNT_W-1:0] ones_next;
    logic [CNT_W-1:0] zeros_next;
    logic [CNT_W-1:0] changes_next;
    logic [WINDOW-2:0] edge_bits;

    always_comb
    begin
        for (int k = 1; k < WINDOW; k++)
        begin
            edge_bits[k-1] = window_bits[k] ^ window_bits[k-1];
        end
    end

    always_comb
    begin
        ones_next    = '0;
        changes_next = '0;
        for (int k = 0; k < WINDOW; k++)
        begin
            ones_next = ones_next + CNT_W'(window_bits[k]);
        end
        for (int k = 0; k < WINDOW - 1; k++)
        begin
            changes_next = changes_next + CNT_W'(edge_bits[k]);
        end
        zeros_next = CNT_W'(WINDOW) - ones_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ones_reg    <= ones_next;
            zeros_reg   <= zeros_next;
            changes_reg <= changes_next;
        end
    end

    assign ones    = ones_reg;
    assign zeros   = zeros_reg;
    assign changes = changes_reg;

endmodule

@@ sv/wmf_merge.sv @@
// ============================================================================
// Window majority filter merge stage
// Decides each channel level from the lane counts and the held levels, and
// keeps the result word, which doubles as the held level state.
// ============================================================================
module wmf_merge
    import wmf_pkg::*;
#(
    parameter int LANES = 16,
    parameter int CNT_W = 3
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  cfg_t                   cfg,
    input  logic [LANES*CNT_W-1:0] ones_all,
    input  logic [LANES*CNT_W-1:0] zeros_all,
    input  logic [LANES*CNT_W-1:0] changes_all,
    output logic [WORD_W-1:0]      levels
);

    localparam int CMP_W = (CNT_W > MA_W) ? CNT_W : MA_W;

    logic [LANES-1:0] levels_reg;
    logic [LANES-1:0] levels_next;
    logic [CMP_W-1:0] limit_ext;
    logic [CMP_W-1:0] agree_ext;

    assign limit_ext = CMP_W'(cfg.change_limit);
    assign agree_ext = CMP_W'(cfg.min_agree);

    always_comb
    begin
        logic [CMP_W-1:0] ones_c;
        logic [CMP_W-1:0] zeros_c;
        logic [CMP_W-1:0] changes_c;
        for (int ch = 0; ch < LANES; ch++)
        begin
            ones_c    = CMP_W'(ones_all[ch*CNT_W +: CNT_W]);
            zeros_c   = CMP_W'(zeros_all[ch*CNT_W +: CNT_W]);
            changes_c = CMP_W'(changes_all[ch*CNT_W +: CNT_W]);
            if (changes_c > limit_ext)
            begin
                if (zeros_c >= agree_ext)
                begin
                    levels_next[ch] = 1'b0;
                end
                else if (ones_c >= agree_ext)
                begin
                    levels_next[ch] = 1'b1;
                end
                else
                begin
                    levels_next[ch] = levels_reg[ch];
                end
            end
            else
            begin
                levels_next[ch] = (zeros_c > ones_c) ? 1'b0 : 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= '0;
        end
        else if (load)
        begin
            levels_reg <= levels_next;
        end
    end

    assign levels = WORD_W'(levels_reg);

endmodule

@@ sv/window_majority_input_filter.sv @@
// ============================================================================
// Window majority input filter
// Debounces up to sixteen digital inputs by majority vote over a sliding
// window of samples, with a stricter agreement rule for chattering inputs.
// ============================================================================
// An accepted request passes through the sample window, lane counters and
// merge register before its result is valid. Throughput is one request
// per cycle when out_stall is low, set by the three-stage pipeline of
// sample window, per-channel lane counters and the merge register.
// Reset clears the sample window and the held levels to all zeros and loads
// change_limit with 2 and min_agree with 3.
module window_majority_input_filter
    import wmf_pkg::*;
#(
    parameter int WINDOW   = 5,
    parameter int CHANNELS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [WORD_W-1:0]    raw_sample,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [WORD_W-1:0]    filtered_levels,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int LANES = (CHANNELS < WORD_W) ? CHANNELS : WORD_W;
    localparam int CNT_W = $clog2(WINDOW + 1);

    logic [LANES-1:0]       window_reg [WINDOW];
    logic [LANES-1:0]       window_next [WINDOW];
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic                   s2_valid_reg;
    logic                   s2_valid_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    cfg_t                   cfg_reg;
    cfg_t                   cfg_next;
    logic                   out_ready;
    logic                   s2_ready;
    logic                   s1_ready;
    logic                   in_accept;
    logic                   s1_adv;
    logic                   s2_adv;
    logic [LANES*CNT_W-1:0] ones_all;
    logic [LANES*CNT_W-1:0] zeros_all;
    logic [LANES*CNT_W-1:0] changes_all;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_stall  = !s1_ready;
    assign in_accept = in_valid && s1_ready;
    assign s1_adv    = s1_valid_reg && s2_ready;
    assign s2_adv    = s2_valid_reg && out_ready;

    always_comb
    begin
        s1_valid_next  = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        s2_valid_next  = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_reg);
        out_valid_next = s2_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_comb
    begin
        window_next[0] = raw_sample[LANES-1:0];
        for (int k = 1; k < WINDOW; k++)
        begin
            window_next[k] = window_reg[k-1];
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_CHANGE_LIMIT: cfg_next.change_limit = cfg_data[CL_W-1:0];
                CFG_MIN_AGREE:    cfg_next.min_agree    = cfg_data[MA_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg         <= 1'b0;
            s2_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            cfg_reg.change_limit <= CHANGE_LIMIT_RST;
            cfg_reg.min_agree    <= MIN_AGREE_RST;
            for (int k = 0; k < WINDOW; k++)
            begin
                window_reg[k] <= '0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
            if (in_accept)
            begin
                for (int k = 0; k < WINDOW; k++)
                begin
                    window_reg[k] <= window_next[k];
                end
            end
        end
    end

    for (genvar ch = 0; ch < LANES; ch++)
    begin : g_lane
        logic [WINDOW-1:0] bits;

        always_comb
        begin
            for (int k = 0; k < WINDOW; k++)
            begin
                bits[k] = window_reg[k][ch];
            end
        end

        wmf_lane #(
            .WINDOW (WINDOW),
            .CNT_W  (CNT_W)
        ) u_lane (
            .clk         (clk),
            .load        (s1_adv),
            .window_bits (bits),
            .ones        (ones_all[ch*CNT_W +: CNT_W]),
            .zeros       (zeros_all[ch*CNT_W +: CNT_W]),
            .changes     (changes_all[ch*CNT_W +: CNT_W])
        );
    end

    wmf_merge #(
        .LANES (LANES),
        .CNT_W (CNT_W)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (s2_adv),
        .cfg         (cfg_reg),
        .ones_all    (ones_all),
        .zeros_all   (zeros_all),
        .changes_all (changes_all),
        .levels      (filtered_levels)
    );

    assign out_valid = out_valid_reg;

    a_in_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("Accepted request did not enter the window stage.");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready) |=> (s1_valid_reg && $stable(window_reg[0])))
        else $error("Window stage changed while the lane stage was full.");

    a_s2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s2_adv |=> out_valid_reg)
        else $error("Lane counts advanced without producing a result.");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !out_ready) |=> s2_valid_reg)
        else $error("Lane stage lost a request while the output was stalled.");

endmodule

@@ tb/wmf_checker.sv @@
// ============================================================================
// Window majority input filter checker
// Watches the request, result and register write ports of the filter. It
// keeps its own sample ring, held levels and register copy, predicts the
// filtered word for each accepted request, and compares each accepted result
// in order against the oldest prediction still waiting.
// ============================================================================
module wmf_checker
    import wmf_pkg::*;
#(
    parameter int WINDOW   = 5,
    parameter int CHANNELS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [WORD_W-1:0]    raw_sample,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [WORD_W-1:0]    filtered_levels,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   mismatch_count,
    output int                   levels_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [WORD_W-1:0] CH_MASK =
        (CHANNELS >= WORD_W) ? '1 : WORD_W'((1 << CHANNELS) - 1);

    logic [WORD_W-1:0] ring [WINDOW];
    int unsigned       next_slot;
    logic [WORD_W-1:0] held;
    cfg_t              cfg;
    logic [WORD_W-1:0] levels_due [$];
    logic [WORD_W-1:0] due;

    function automatic logic [WORD_W-1:0] predict_levels(input logic [WORD_W-1:0] sample);
        int unsigned       oldest;
        int unsigned       idx;
        int unsigned       ones;
        int unsigned       zeros;
        int unsigned       toggles;
        logic              lvl;
        logic              prev_lvl;
        logic              decided;
        logic [WORD_W-1:0] levels;
        ring[next_slot] = sample & CH_MASK;
        oldest = (next_slot + 1) % WINDOW;
        next_slot = oldest;
        levels = '0;
        for (int ch = 0; ch < CHANNELS && ch < WORD_W; ch++)
        begin
            ones = 0;
            zeros = 0;
            toggles = 0;
            prev_lvl = 1'b0;
            for (int k = 0; k < WINDOW; k++)
            begin
                idx = (oldest + k) % WINDOW;
                lvl = ring[idx][ch];
                if (lvl)
                    ones++;
                else
                    zeros++;
                if (k > 0 && lvl != prev_lvl)
                    toggles++;
                prev_lvl = lvl;
            end
            if (toggles > cfg.change_limit)
            begin
                if (zeros >= cfg.min_agree)
                    decided = 1'b0;
                else if (ones >= cfg.min_agree)
                    decided = 1'b1;
                else
                    decided = held[ch];
            end
            else
            begin
                decided = (zeros > ones) ? 1'b0 : 1'b1;
            end
            levels[ch] = decided;
        end
        held = levels & CH_MASK;
        return levels;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
                ring[i] = '0;
            next_slot = 0;
            held = '0;
            cfg.change_limit = CHANGE_LIMIT_RST;
            cfg.min_agree = MIN_AGREE_RST;
            levels_due.delete();
            mismatch_count <= 0;
            levels_outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_CHANGE_LIMIT)
                    cfg.change_limit = cfg_data[CL_W-1:0];
                else if (cfg_index == CFG_MIN_AGREE)
                    cfg.min_agree = cfg_data[MA_W-1:0];
            end
            if (in_valid && !in_stall)
                levels_due.push_back(predict_levels(raw_sample));
            if (out_valid && !out_stall)
            begin
                if (levels_due.size() == 0)
                begin
                    $error("filtered_levels: expected none, actual %h", filtered_levels);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    due = levels_due.pop_front();
                    if (filtered_levels !== due)
                    begin
                        $error("filtered_levels: expected %h, actual %h", due,
                               filtered_levels);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            levels_outstanding <= levels_due.size();
        end
    end

endmodule

@@ tb/tb_window_majority_input_filter.sv @@
// ============================================================================
// Window majority input filter testbench
// Drives raw sample words through the filter under several register settings
// and idle patterns, including a long result hold-off that backs up the
// pipeline. A separate checker predicts and compares every result.
// ============================================================================
module tb_window_majority_input_filter
    import wmf_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 150;

    typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [WORD_W-1:0]    raw_sample = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [WORD_W-1:0]    filtered_levels;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_CHANGE_LIMIT;
    logic [CFG_W-1:0]     cfg_data = '0;

    int                   mismatch_count;
    int                   levels_outstanding;
    int                   send_idle_pct = 0;
    int                   stall_pct = 0;
    int                   holds_asked = 0;
    int                   holds_granted = 0;
    int                   hold_left = 0;
    int                   cycle_count = 0;
    logic [WORD_W-1:0]    last_word = '0;

    window_majority_input_filter dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .raw_sample      (raw_sample),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .filtered_levels (filtered_levels),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    wmf_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .raw_sample         (raw_sample),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .filtered_levels    (filtered_levels),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .mismatch_count     (mismatch_count),
        .levels_outstanding (levels_outstanding)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // The long hold-off is counted here so that the sender keeps offering
    // requests while the filter fills up.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (holds_asked != holds_granted)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            holds_granted <= holds_granted + 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_sample(input logic [WORD_W-1:0] word);
        in_valid <= 1'b1;
        raw_sample <= word;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        last_word = word;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            raw_sample <= WORD_W'($urandom);
            @(posedge clk);
        end
    endtask

    function automatic logic [WORD_W-1:0] bouncy_word(input logic [WORD_W-1:0] prev);
        int pick;
        pick = $urandom_range(9);
        if (pick < 3)
            return WORD_W'($urandom);
        else if (pick < 8)
            return prev ^ WORD_W'($urandom & $urandom & $urandom);
        else if (pick == 8)
            return ~prev;
        else
            return prev;
    endfunction

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (levels_outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(value);
        @(posedge clk);
    endtask

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 54; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 54; end
            default:       begin send_idle_pct = 32; stall_pct = 32; end
        endcase
    endtask

    task automatic run_phase(input int change_limit, input int min_agree,
                             input idle_mode_t mode, input bit with_hold);
        wait_idle();
        write_reg(CFG_CHANGE_LIMIT, change_limit);
        write_reg(CFG_MIN_AGREE, min_agree);
        cfg_we <= 1'b0;
        set_idle(mode);
        if (with_hold)
            holds_asked = holds_asked + 1;
        for (int i = 0; i < PHASE_ITEMS; i++)
            send_sample(bouncy_word(last_word));
    endtask

    initial
    begin
        logic [WORD_W-1:0] directed [$];
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Early requests see the cleared ring as low samples.
        directed = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                     16'h0001, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h00FF,
                     16'hFF00, 16'h00FF, 16'hFF00, 16'h0F0F};
        set_idle(IDLE_NONE);
        foreach (directed[i])
            send_sample(directed[i]);
        for (int i = 0; i < PHASE_ITEMS - 20; i++)
            send_sample(bouncy_word(last_word));

        run_phase(0, 1, IDLE_NONE, 1'b1);
        run_phase(15, 16, IDLE_SENDER, 1'b0);
        run_phase(0, 0, IDLE_RECEIVER, 1'b0);
        run_phase(1, 31, IDLE_BOTH, 1'b0);
        run_phase(0, 6, IDLE_NONE, 1'b0);
        run_phase(3, 2, IDLE_SENDER, 1'b0);
        run_phase(1, 4, IDLE_RECEIVER, 1'b0);
        run_phase(2, 5, IDLE_BOTH, 1'b1);

        wait_idle();
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
